[sv/mbpq_pkg.sv]
// Package for the buffer pool queue manager: item types, status and op codes,
// sizing constants and the microcode table of the control sequencer.
// No dependencies.
`timescale 1ns / 1ps

package mbpq_pkg;

    // sizing defaults and the shared end-of-list code
    localparam int POOL_SIZE_DEF   = 16;
    localparam int QUEUE_COUNT_DEF = 16;
    localparam int LINK_W          = 5;
    localparam logic [LINK_W-1:0] LINK_NONE = 5'd31;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_POST    = 2'd2,
        OP_GET     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_INVALID      = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_NO_ROUTE     = 3'd4,
        ST_BAD_QUEUE    = 3'd5
    } t_status;

    // input and result items
    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] buffer_index;
        logic [7:0] service_code;
        logic [3:0] queue_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] result_index;
    } t_out_item;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LD_HEAD,     // ptr = head of selected queue, clear walk count
        ACT_POP,         // unlink head of selected queue
        ACT_REL_WALK,    // release: compare and follow one free-list link
        ACT_PUSH_FREE,   // push buffer on free list
        ACT_SEL_ROUTE,   // queue = route nibble of service code
        ACT_POST_START,  // clear buffer link, ptr = queue head
        ACT_TAIL_WALK,   // post: follow one link toward the tail
        ACT_LINK_TAIL,   // tail link = buffer
        ACT_SET_HEAD     // head of empty queue = buffer
    } t_act;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_BUF_BAD,
        C_PTR_BAD,
        C_QN_BAD,
        C_Q_ZERO,
        C_Q_BAD,
        C_REL_EXIT,
        C_HIT,
        C_POST_EXIT
    } t_cond;

    typedef logic [4:0] t_pc;

    typedef struct packed {
        t_act    act;
        t_cond   cond;
        logic    done;
        t_status status;
        t_pc     jump;
        t_pc     next;
    } t_uword;

    // program addresses
    localparam t_pc PC_GET       = 5'd0;
    localparam t_pc PC_ALLOC     = 5'd1;
    localparam t_pc PC_ALLOC_CHK = 5'd2;
    localparam t_pc PC_POP       = 5'd3;
    localparam t_pc PC_REL       = 5'd4;
    localparam t_pc PC_REL_WALK  = 5'd5;
    localparam t_pc PC_REL_CHK   = 5'd6;
    localparam t_pc PC_REL_PUSH  = 5'd7;
    localparam t_pc PC_POST      = 5'd8;
    localparam t_pc PC_POST_RZ   = 5'd9;
    localparam t_pc PC_POST_RQ   = 5'd10;
    localparam t_pc PC_POST_LD   = 5'd11;
    localparam t_pc PC_POST_CHK  = 5'd12;
    localparam t_pc PC_POST_WALK = 5'd13;
    localparam t_pc PC_POST_LINK = 5'd14;
    localparam t_pc PC_POST_HEAD = 5'd15;
    localparam t_pc PC_E_EMPTY   = 5'd16;
    localparam t_pc PC_E_INVALID = 5'd17;
    localparam t_pc PC_E_ALREADY = 5'd18;
    localparam t_pc PC_E_NOROUTE = 5'd19;
    localparam t_pc PC_E_BADQ    = 5'd20;

    function automatic t_uword uw(t_act a, t_cond c, logic d, t_status s, t_pc j, t_pc n);
        t_uword w;
        w.act    = a;
        w.cond   = c;
        w.done   = d;
        w.status = s;
        w.jump   = j;
        w.next   = n;
        return w;
    endfunction

    // microcode table: jump when the condition holds, else go to next
    function automatic t_uword urom(t_pc pc);
        t_uword w;
        case (pc)
            PC_GET:       w = uw(ACT_NOP, C_QN_BAD, 1'b0, ST_OK, PC_E_BADQ, PC_ALLOC);
            PC_ALLOC:     w = uw(ACT_LD_HEAD, C_NEVER, 1'b0, ST_OK, PC_ALLOC_CHK, PC_ALLOC_CHK);
            PC_ALLOC_CHK: w = uw(ACT_NOP, C_PTR_BAD, 1'b0, ST_OK, PC_E_EMPTY, PC_POP);
            PC_POP:       w = uw(ACT_POP, C_NEVER, 1'b1, ST_OK, PC_GET, PC_GET);
            PC_REL:       w = uw(ACT_LD_HEAD, C_BUF_BAD, 1'b0, ST_OK, PC_E_INVALID,
                                 PC_REL_WALK);
            PC_REL_WALK:  w = uw(ACT_REL_WALK, C_REL_EXIT, 1'b0, ST_OK, PC_REL_CHK,
                                 PC_REL_WALK);
            PC_REL_CHK:   w = uw(ACT_NOP, C_HIT, 1'b0, ST_OK, PC_E_ALREADY, PC_REL_PUSH);
            PC_REL_PUSH:  w = uw(ACT_PUSH_FREE, C_NEVER, 1'b1, ST_OK, PC_GET, PC_GET);
            PC_POST:      w = uw(ACT_SEL_ROUTE, C_BUF_BAD, 1'b0, ST_OK, PC_E_INVALID,
                                 PC_POST_RZ);
            PC_POST_RZ:   w = uw(ACT_NOP, C_Q_ZERO, 1'b0, ST_OK, PC_E_NOROUTE, PC_POST_RQ);
            PC_POST_RQ:   w = uw(ACT_NOP, C_Q_BAD, 1'b0, ST_OK, PC_E_BADQ, PC_POST_LD);
            PC_POST_LD:   w = uw(ACT_POST_START, C_NEVER, 1'b0, ST_OK, PC_POST_CHK,
                                 PC_POST_CHK);
            PC_POST_CHK:  w = uw(ACT_NOP, C_PTR_BAD, 1'b0, ST_OK, PC_POST_HEAD,
                                 PC_POST_WALK);
            PC_POST_WALK: w = uw(ACT_TAIL_WALK, C_POST_EXIT, 1'b0, ST_OK, PC_POST_LINK,
                                 PC_POST_WALK);
            PC_POST_LINK: w = uw(ACT_LINK_TAIL, C_NEVER, 1'b1, ST_OK, PC_GET, PC_GET);
            PC_POST_HEAD: w = uw(ACT_SET_HEAD, C_NEVER, 1'b1, ST_OK, PC_GET, PC_GET);
            PC_E_EMPTY:   w = uw(ACT_NOP, C_NEVER, 1'b1, ST_EMPTY, PC_GET, PC_GET);
            PC_E_INVALID: w = uw(ACT_NOP, C_NEVER, 1'b1, ST_INVALID, PC_GET, PC_GET);
            PC_E_ALREADY: w = uw(ACT_NOP, C_NEVER, 1'b1, ST_ALREADY_FREE, PC_GET, PC_GET);
            PC_E_NOROUTE: w = uw(ACT_NOP, C_NEVER, 1'b1, ST_NO_ROUTE, PC_GET, PC_GET);
            PC_E_BADQ:    w = uw(ACT_NOP, C_NEVER, 1'b1, ST_BAD_QUEUE, PC_GET, PC_GET);
            default:      w = uw(ACT_NOP, C_NEVER, 1'b1, ST_OK, PC_GET, PC_GET);
        endcase
        return w;
    endfunction

    // program entry for each operation
    function automatic t_pc entry_pc(logic [1:0] op);
        t_pc pc;
        case (op)
            OP_ALLOC:   pc = PC_ALLOC;
            OP_RELEASE: pc = PC_REL;
            OP_POST:    pc = PC_POST;
            default:    pc = PC_GET;
        endcase
        return pc;
    endfunction

endpackage

[sv/message_buffer_pool_queues.sv]
// Buffer pool manager: linked-list queues over a pool of buffer indices,
// run by a microcoded sequencer. Depends on mbpq_pkg.
//
// The list walks read one link per cycle from the link table. One item at a
// time: busy is high until the strobe, and the next start can be taken while
// the strobe is high. The strobe is high for a single cycle; the result
// payload is held until the next item finishes. Synchronous reset restores
// the full free list, empty task queues and a zero route table.
`timescale 1ns / 1ps

module message_buffer_pool_queues #(
    parameter int POOL_SIZE   = mbpq_pkg::POOL_SIZE_DEF,
    parameter int QUEUE_COUNT = mbpq_pkg::QUEUE_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mbpq_pkg::t_in_item  i_item,
    output logic                o_done,
    output mbpq_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [63:0]         i_cfg_data
);
    import mbpq_pkg::*;

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);

    // list tables
    logic [LINK_W-1:0] r_heads [QUEUE_COUNT];
    logic [LINK_W-1:0] r_links [POOL_SIZE];

    // sequencer and datapath registers
    logic              r_busy;
    t_pc               r_pc;
    t_pc               n_pc;
    logic [63:0]       r_route;
    logic [4:0]        r_buf;
    logic [7:0]        r_svc;
    logic [3:0]        r_q;
    logic [LINK_W-1:0] r_ptr;
    logic [CW-1:0]     r_cnt;
    logic              r_hit;
    logic              r_done;
    t_out_item         r_result;

    t_uword            cw;
    logic              accept;
    logic              ptr_ok, buf_ok, next_ok, ptr_eq, rel_exit, post_exit, cond_true;
    logic [LINK_W-1:0] head_rd, link_rd;
    logic [3:0]        route_q;

    assign accept = start && !r_busy;
    assign cw     = urom(r_pc);

    // table reads, one address each
    assign head_rd = r_heads[r_q[QW-1:0]];
    assign ptr_ok  = r_ptr < LINK_W'(POOL_SIZE);
    assign link_rd = ptr_ok ? r_links[r_ptr[IW-1:0]] : LINK_NONE;
    assign next_ok = link_rd < LINK_W'(POOL_SIZE);
    assign buf_ok  = r_buf < LINK_W'(POOL_SIZE);
    assign ptr_eq  = r_ptr == r_buf;
    assign route_q = r_route[{r_svc[7:4], 2'b00} +: 4];

    assign rel_exit  = !ptr_ok || ptr_eq || (r_cnt == CW'(POOL_SIZE - 1));
    assign post_exit = !next_ok || (r_cnt == CW'(POOL_SIZE));

    // jump condition select
    always_comb begin
        case (cw.cond)
            C_BUF_BAD:   cond_true = !buf_ok;
            C_PTR_BAD:   cond_true = !ptr_ok;
            C_QN_BAD:    cond_true = (r_q == 4'd0) || ({1'b0, r_q} >= 5'(QUEUE_COUNT));
            C_Q_ZERO:    cond_true = r_q == 4'd0;
            C_Q_BAD:     cond_true = {1'b0, r_q} >= 5'(QUEUE_COUNT);
            C_REL_EXIT:  cond_true = rel_exit;
            C_HIT:       cond_true = r_hit;
            C_POST_EXIT: cond_true = post_exit;
            default:     cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_pc = cond_true ? cw.jump : cw.next;
    end

    // route register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route <= '0;
        end else if (i_cfg_we) begin
            r_route <= i_cfg_data;
        end
    end

    // sequencer control and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_GET;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (accept) begin
                r_busy <= 1'b1;
                r_pc   <= entry_pc(i_item.operation);
            end else if (r_busy) begin
                if (cw.done) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_pc <= n_pc;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_busy && cw.done) begin
            r_result.status       <= cw.status;
            r_result.result_index <= (cw.act == ACT_POP) ? r_ptr[3:0] : 4'd0;
        end
    end

    // operand latches and walk registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= i_item.buffer_index;
            r_svc <= i_item.service_code;
            r_q   <= (i_item.operation == OP_GET) ? i_item.queue_number : 4'd0;
            r_hit <= 1'b0;
        end else if (r_busy) begin
            case (cw.act)
                ACT_LD_HEAD: begin
                    r_ptr <= head_rd;
                    r_cnt <= '0;
                end
                ACT_REL_WALK: begin
                    r_hit <= ptr_ok && ptr_eq;
                    r_ptr <= link_rd;
                    r_cnt <= r_cnt + CW'(1);
                end
                ACT_SEL_ROUTE: begin
                    r_q <= route_q;
                end
                ACT_POST_START: begin
                    r_ptr <= head_rd;
                    r_cnt <= CW'(1);
                end
                ACT_TAIL_WALK: begin
                    if (!post_exit) begin
                        r_ptr <= link_rd;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // list table updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_heads[i] <= (i == 0) ? LINK_W'(0) : LINK_NONE;
            end
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_links[i] <= (i == POOL_SIZE - 1) ? LINK_NONE : LINK_W'(i + 1);
            end
        end else if (r_busy && !accept) begin
            case (cw.act)
                ACT_POP: begin
                    r_heads[r_q[QW-1:0]]  <= link_rd;
                    r_links[r_ptr[IW-1:0]] <= LINK_NONE;
                end
                ACT_PUSH_FREE: begin
                    r_links[r_buf[IW-1:0]] <= head_rd;
                    r_heads[r_q[QW-1:0]]   <= r_buf;
                end
                ACT_POST_START: begin
                    r_links[r_buf[IW-1:0]] <= LINK_NONE;
                end
                ACT_LINK_TAIL: begin
                    r_links[r_ptr[IW-1:0]] <= r_buf;
                end
                ACT_SET_HEAD: begin
                    r_heads[r_q[QW-1:0]] <= r_buf;
                end
                default: begin
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
